// ===== hw/rtl/rvex_pkg.sv =====
package rvex_pkg;

    localparam int unsigned SHAMT_W = 5;

    localparam logic [2:0] MODE_R  = 3'd0;
    localparam logic [2:0] MODE_I  = 3'd1;
    localparam logic [2:0] MODE_SB = 3'd2;
    localparam logic [2:0] MODE_UJ = 3'd3;

    localparam logic [6:0] OPC_REG   = 7'b0110011;
    localparam logic [6:0] OPC_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC = 7'b0010111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [31:0] CLEAR_BIT0 = ~32'h1;
    localparam logic [31:0] LINK_STEP  = 32'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_SLT,
        OP_SLTU,
        OP_XOR,
        OP_OR,
        OP_AND,
        OP_SLL,
        OP_SRL,
        OP_SRA,
        OP_BEQ,
        OP_BNE,
        OP_BLT,
        OP_BGE,
        OP_BLTU,
        OP_BGEU,
        OP_JAL,
        OP_JALR,
        OP_LUI,
        OP_AUIPC
    } t_alu_op;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  opcode;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [4:0]  shift_field;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
        logic [31:0] immediate;
        logic [31:0] pc_value;
    } t_in_word;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_value;
        logic        jump_taken;
        logic [31:0] jump_target;
    } t_out_word;

    // decoded operation with its operands
    typedef struct packed {
        t_alu_op              op;
        logic [31:0]          opa;
        logic [31:0]          opb;
        logic [SHAMT_W-1:0]   shamt;
        logic [31:0]          imm;
        logic [31:0]          pc;
    } t_dec_word;

    // ALU result plus compare flags for branch resolution
    typedef struct packed {
        t_alu_op     op;
        logic [31:0] wval;
        logic [31:0] target;
        logic        eq;
        logic        lt;
        logic        ltu;
    } t_alu_word;

endpackage

// ===== hw/rtl/rvex_dec.sv =====
module rvex_dec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rvex_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output rvex_pkg::t_dec_word o_word
);

    logic                r_valid;
    rvex_pkg::t_dec_word r_word;
    rvex_pkg::t_dec_word n_word;

    always_comb begin
        n_word.op    = rvex_pkg::OP_NONE;
        n_word.opa   = i_word.src1_value;
        n_word.opb   = i_word.src2_value;
        n_word.shamt = i_word.src2_value[rvex_pkg::SHAMT_W-1:0];
        n_word.imm   = i_word.immediate;
        n_word.pc    = i_word.pc_value;
        case (i_word.mode)
            rvex_pkg::MODE_R: begin
                if (i_word.funct7 == rvex_pkg::F7_BASE && i_word.funct3 == rvex_pkg::F3_ADD) begin
                    n_word.op = rvex_pkg::OP_ADD;
                end else if (i_word.funct7 == rvex_pkg::F7_ALT
                             && i_word.funct3 == rvex_pkg::F3_ADD) begin
                    n_word.op = rvex_pkg::OP_SUB;
                end else if (i_word.opcode == rvex_pkg::OPC_REG
                             && i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SLL) begin
                    n_word.op = rvex_pkg::OP_SLL;
                end else if (i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SLT) begin
                    n_word.op = rvex_pkg::OP_SLT;
                end else if (i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SLTU) begin
                    n_word.op = rvex_pkg::OP_SLTU;
                end else if (i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_XOR) begin
                    n_word.op = rvex_pkg::OP_XOR;
                end else if (i_word.opcode == rvex_pkg::OPC_REG
                             && i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SR) begin
                    n_word.op = rvex_pkg::OP_SRL;
                end else if (i_word.opcode == rvex_pkg::OPC_REG
                             && i_word.funct7 == rvex_pkg::F7_ALT
                             && i_word.funct3 == rvex_pkg::F3_SR) begin
                    n_word.op = rvex_pkg::OP_SRA;
                end else if (i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_OR) begin
                    n_word.op = rvex_pkg::OP_OR;
                end else if (i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_AND) begin
                    n_word.op = rvex_pkg::OP_AND;
                end else if (i_word.opcode == rvex_pkg::OPC_IMM
                             && i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SLL) begin
                    n_word.op    = rvex_pkg::OP_SLL;
                    n_word.shamt = i_word.shift_field;
                end else if (i_word.opcode == rvex_pkg::OPC_IMM
                             && i_word.funct7 == rvex_pkg::F7_BASE
                             && i_word.funct3 == rvex_pkg::F3_SR) begin
                    n_word.op    = rvex_pkg::OP_SRL;
                    n_word.shamt = i_word.shift_field;
                end else if (i_word.opcode == rvex_pkg::OPC_IMM
                             && i_word.funct7 == rvex_pkg::F7_ALT
                             && i_word.funct3 == rvex_pkg::F3_SR) begin
                    n_word.op    = rvex_pkg::OP_SRA;
                    n_word.shamt = i_word.shift_field;
                end
            end
            rvex_pkg::MODE_I: begin
                if (i_word.opcode == rvex_pkg::OPC_IMM) begin
                    n_word.opb = i_word.immediate;
                    case (i_word.funct3)
                        rvex_pkg::F3_ADD:  n_word.op = rvex_pkg::OP_ADD;
                        rvex_pkg::F3_SLT:  n_word.op = rvex_pkg::OP_SLT;
                        rvex_pkg::F3_SLTU: n_word.op = rvex_pkg::OP_SLTU;
                        rvex_pkg::F3_XOR:  n_word.op = rvex_pkg::OP_XOR;
                        rvex_pkg::F3_OR:   n_word.op = rvex_pkg::OP_OR;
                        rvex_pkg::F3_AND:  n_word.op = rvex_pkg::OP_AND;
                        default:           n_word.op = rvex_pkg::OP_NONE;
                    endcase
                end else if (i_word.opcode == rvex_pkg::OPC_JALR) begin
                    n_word.op = rvex_pkg::OP_JALR;
                end else if (i_word.opcode == rvex_pkg::OPC_LUI) begin
                    n_word.op = rvex_pkg::OP_LUI;
                end else if (i_word.opcode == rvex_pkg::OPC_AUIPC) begin
                    n_word.op = rvex_pkg::OP_AUIPC;
                end
            end
            rvex_pkg::MODE_SB: begin
                case (i_word.funct3)
                    rvex_pkg::F3_BEQ:  n_word.op = rvex_pkg::OP_BEQ;
                    rvex_pkg::F3_BNE:  n_word.op = rvex_pkg::OP_BNE;
                    rvex_pkg::F3_BLT:  n_word.op = rvex_pkg::OP_BLT;
                    rvex_pkg::F3_BGE:  n_word.op = rvex_pkg::OP_BGE;
                    rvex_pkg::F3_BLTU: n_word.op = rvex_pkg::OP_BLTU;
                    rvex_pkg::F3_BGEU: n_word.op = rvex_pkg::OP_BGEU;
                    default:           n_word.op = rvex_pkg::OP_NONE;
                endcase
            end
            rvex_pkg::MODE_UJ: begin
                n_word.op = rvex_pkg::OP_JAL;
            end
            default: begin
                // U/S class and unused modes: only LUI and AUIPC write
                if (i_word.opcode == rvex_pkg::OPC_LUI) begin
                    n_word.op = rvex_pkg::OP_LUI;
                end else if (i_word.opcode == rvex_pkg::OPC_AUIPC) begin
                    n_word.op = rvex_pkg::OP_AUIPC;
                end
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/rvex_alu.sv =====
module rvex_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rvex_pkg::t_dec_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rvex_pkg::t_alu_word o_word
);

    logic                r_valid;
    rvex_pkg::t_alu_word r_word;
    rvex_pkg::t_alu_word n_word;

    logic [31:0] sum;
    logic [31:0] diff;
    logic [31:0] tbase;
    logic [31:0] tsum;
    logic [31:0] link;
    logic        lt_s;
    logic        lt_u;

    always_comb begin
        sum   = i_word.opa + i_word.opb;
        diff  = i_word.opa - i_word.opb;
        // JALR targets rs1 + imm, everything else pc + imm
        tbase = (i_word.op == rvex_pkg::OP_JALR) ? i_word.opa : i_word.pc;
        tsum  = tbase + i_word.imm;
        link  = i_word.pc + rvex_pkg::LINK_STEP;
        lt_s  = $signed(i_word.opa) < $signed(i_word.opb);
        lt_u  = i_word.opa < i_word.opb;

        n_word.op     = i_word.op;
        n_word.target = tsum;
        n_word.eq     = (i_word.opa == i_word.opb);
        n_word.lt     = lt_s;
        n_word.ltu    = lt_u;
        case (i_word.op)
            rvex_pkg::OP_ADD:   n_word.wval = sum;
            rvex_pkg::OP_SUB:   n_word.wval = diff;
            rvex_pkg::OP_SLT:   n_word.wval = {31'd0, lt_s};
            rvex_pkg::OP_SLTU:  n_word.wval = {31'd0, lt_u};
            rvex_pkg::OP_XOR:   n_word.wval = i_word.opa ^ i_word.opb;
            rvex_pkg::OP_OR:    n_word.wval = i_word.opa | i_word.opb;
            rvex_pkg::OP_AND:   n_word.wval = i_word.opa & i_word.opb;
            rvex_pkg::OP_SLL:   n_word.wval = i_word.opa << i_word.shamt;
            rvex_pkg::OP_SRL:   n_word.wval = i_word.opa >> i_word.shamt;
            rvex_pkg::OP_SRA:   n_word.wval = $unsigned($signed(i_word.opa) >>> i_word.shamt);
            rvex_pkg::OP_JAL,
            rvex_pkg::OP_JALR:  n_word.wval = link;
            rvex_pkg::OP_LUI:   n_word.wval = i_word.imm;
            rvex_pkg::OP_AUIPC: n_word.wval = tsum;
            default:            n_word.wval = 32'd0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/rvex_wb.sv =====
module rvex_wb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rvex_pkg::t_alu_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rvex_pkg::t_out_word o_word
);

    logic                r_valid;
    rvex_pkg::t_out_word r_word;
    rvex_pkg::t_out_word n_word;

    logic taken;
    logic wen;

    always_comb begin
        case (i_word.op)
            rvex_pkg::OP_BEQ:  taken = i_word.eq;
            rvex_pkg::OP_BNE:  taken = !i_word.eq;
            rvex_pkg::OP_BLT:  taken = i_word.lt;
            rvex_pkg::OP_BGE:  taken = !i_word.lt;
            rvex_pkg::OP_BLTU: taken = i_word.ltu;
            rvex_pkg::OP_BGEU: taken = !i_word.ltu;
            rvex_pkg::OP_JAL,
            rvex_pkg::OP_JALR: taken = 1'b1;
            default:           taken = 1'b0;
        endcase

        case (i_word.op)
            rvex_pkg::OP_NONE, rvex_pkg::OP_BEQ, rvex_pkg::OP_BNE, rvex_pkg::OP_BLT,
            rvex_pkg::OP_BGE, rvex_pkg::OP_BLTU, rvex_pkg::OP_BGEU: wen = 1'b0;
            default:                                                 wen = 1'b1;
        endcase

        n_word.write_valid = wen;
        n_word.write_value = wen ? i_word.wval : 32'd0;
        n_word.jump_taken  = taken;
        if (!taken) begin
            n_word.jump_target = 32'd0;
        end else if (i_word.op == rvex_pkg::OP_JALR) begin
            n_word.jump_target = i_word.target & rvex_pkg::CLEAR_BIT0;
        end else begin
            n_word.jump_target = i_word.target;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/rv32i_execute_alu_branch_top.sv =====
// RV32I execute stage: ALU, conditional branches, JAL/JALR, LUI and AUIPC. Each input word
// is one decoded instruction and gives exactly one output word with a register write value
// and a next-PC target, each qualified by its own flag (value reads 0 when its flag is 0).
// Three register stages (decode, ALU/compare, branch resolve and output), which a word
// passes through in that order before o_out_valid rises; a new word is taken every cycle
// unless a stalled output has backed the stages up, and each stage holds its word only while
// the stage after it is full and stalled.
module rv32i_execute_alu_branch_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rvex_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rvex_pkg::t_out_word o_out_word
);

    logic                dec_valid;
    logic                dec_ready;
    rvex_pkg::t_dec_word dec_word;
    logic                alu_valid;
    logic                alu_ready;
    rvex_pkg::t_alu_word alu_word;

    rvex_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_word  (dec_word)
    );

    rvex_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_word  (dec_word),
        .o_valid (alu_valid),
        .i_ready (alu_ready),
        .o_word  (alu_word)
    );

    rvex_wb u_wb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (alu_valid),
        .o_ready (alu_ready),
        .i_word  (alu_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // all three stages full and output stalled: nothing may enter
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_valid && alu_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline full and stalled");

    a_wval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.write_valid) |-> (o_out_word.write_value == 32'd0))
        else $error("write value nonzero without write_valid");

    a_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.jump_taken) |-> (o_out_word.jump_target == 32'd0))
        else $error("jump target nonzero without jump_taken");

    // a word in the ALU stage moves on whenever the output stage frees up
    a_alu_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (alu_valid && (!o_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("ALU stage word lost or not advanced");

endmodule

// ===== sim/rv32i_execute_alu_branch_top_tb.sv =====
module rv32i_execute_alu_branch_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvex_pkg::*;

    localparam logic [2:0] MODE_OTHER = 3'd4;
    localparam logic [2:0] MODE_ALIAS = 3'd7;

    localparam int NUM_RANDOM     = 1870;
    localparam int TAIL_WORDS     = 150;
    localparam int HOLD_AT_WORD   = 400;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      out_ready  = 1'b0;
    t_in_word  in_word    = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_in_word  insn_pending[$];
    t_out_word result_due[$];

    int words_in     = 0;
    int words_out    = 0;
    int n_directed   = 0;
    int n_writes     = 0;
    int n_redirects  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int tx_idle_pct  = 10;
    int rx_idle_pct  = 10;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    rv32i_execute_alu_branch_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // decode in the same priority order as the execute stage
    function automatic t_alu_op decode_insn(input t_in_word w, output logic [31:0] opb,
                                            output logic [4:0] shamt);
        t_alu_op op;
        logic    base;
        logic    alt;
        op    = OP_NONE;
        opb   = w.src2_value;
        shamt = w.src2_value[4:0];
        base  = (w.funct7 == F7_BASE);
        alt   = (w.funct7 == F7_ALT);
        if (w.mode == MODE_R) begin
            if (base && w.funct3 == F3_ADD) op = OP_ADD;
            else if (alt && w.funct3 == F3_ADD) op = OP_SUB;
            else if (w.opcode == OPC_REG && base && w.funct3 == F3_SLL) op = OP_SLL;
            else if (base && w.funct3 == F3_SLT) op = OP_SLT;
            else if (base && w.funct3 == F3_SLTU) op = OP_SLTU;
            else if (base && w.funct3 == F3_XOR) op = OP_XOR;
            else if (w.opcode == OPC_REG && base && w.funct3 == F3_SR) op = OP_SRL;
            else if (w.opcode == OPC_REG && alt && w.funct3 == F3_SR) op = OP_SRA;
            else if (base && w.funct3 == F3_OR) op = OP_OR;
            else if (base && w.funct3 == F3_AND) op = OP_AND;
            else if (w.opcode == OPC_IMM && base && w.funct3 == F3_SLL) op = OP_SLL;
            else if (w.opcode == OPC_IMM && base && w.funct3 == F3_SR) op = OP_SRL;
            else if (w.opcode == OPC_IMM && alt && w.funct3 == F3_SR) op = OP_SRA;
            // immediate shifts take their amount from the rs2 field
            if (w.opcode != OPC_REG && (op == OP_SLL || op == OP_SRL || op == OP_SRA))
                shamt = w.shift_field;
        end else if (w.mode == MODE_I && w.opcode == OPC_IMM) begin
            opb = w.immediate;
            case (w.funct3)
                F3_ADD:  op = OP_ADD;
                F3_SLT:  op = OP_SLT;
                F3_SLTU: op = OP_SLTU;
                F3_XOR:  op = OP_XOR;
                F3_OR:   op = OP_OR;
                F3_AND:  op = OP_AND;
                default: op = OP_NONE;
            endcase
        end else if (w.mode == MODE_SB) begin
            case (w.funct3)
                F3_BEQ:  op = OP_BEQ;
                F3_BNE:  op = OP_BNE;
                F3_BLT:  op = OP_BLT;
                F3_BGE:  op = OP_BGE;
                F3_BLTU: op = OP_BLTU;
                F3_BGEU: op = OP_BGEU;
                default: op = OP_NONE;
            endcase
        end else if (w.mode == MODE_UJ) begin
            op = OP_JAL;
        end else if (w.mode == MODE_I && w.opcode == OPC_JALR) begin
            op = OP_JALR;
        end else if (w.opcode == OPC_LUI) begin
            op = OP_LUI;
        end else if (w.opcode == OPC_AUIPC) begin
            op = OP_AUIPC;
        end
        return op;
    endfunction

    function automatic t_out_word predict_exec(input t_in_word w);
        t_out_word  r;
        t_alu_op    op;
        logic [31:0] a;
        logic [31:0] opb;
        logic [4:0]  sh;
        logic        taken;
        r     = '0;
        taken = 1'b0;
        a     = w.src1_value;
        op    = decode_insn(w, opb, sh);
        case (op)
            OP_ADD:   r.write_value = a + opb;
            OP_SUB:   r.write_value = a - opb;
            OP_SLT:   r.write_value = {31'b0, $signed(a) < $signed(opb)};
            OP_SLTU:  r.write_value = {31'b0, a < opb};
            OP_XOR:   r.write_value = a ^ opb;
            OP_OR:    r.write_value = a | opb;
            OP_AND:   r.write_value = a & opb;
            OP_SLL:   r.write_value = a << sh;
            OP_SRL:   r.write_value = a >> sh;
            OP_SRA:   r.write_value = $signed(a) >>> sh;
            OP_BEQ:   taken = (a == opb);
            OP_BNE:   taken = (a != opb);
            OP_BLT:   taken = ($signed(a) < $signed(opb));
            OP_BGE:   taken = ($signed(a) >= $signed(opb));
            OP_BLTU:  taken = (a < opb);
            OP_BGEU:  taken = (a >= opb);
            OP_JAL:   begin
                r.write_value = w.pc_value + LINK_STEP;
                taken = 1'b1;
            end
            OP_JALR:  begin
                r.write_value = w.pc_value + LINK_STEP;
                taken = 1'b1;
            end
            OP_LUI:   r.write_value = w.immediate;
            OP_AUIPC: r.write_value = w.pc_value + w.immediate;
            default:  r.write_value = '0;
        endcase
        r.write_valid = (op != OP_NONE) && !(op >= OP_BEQ && op <= OP_BGEU);
        r.jump_taken  = taken;
        if (op == OP_JALR)
            r.jump_target = (a + w.immediate) & CLEAR_BIT0;
        else if (taken)
            r.jump_target = w.pc_value + w.immediate;
        return r;
    endfunction

    function automatic t_in_word make_insn(input logic [2:0] mode, input logic [6:0] opc,
                                           input logic [2:0] f3, input logic [6:0] f7,
                                           input logic [4:0] sh, input logic [31:0] a,
                                           input logic [31:0] b, input logic [31:0] imm,
                                           input logic [31:0] pc);
        t_in_word w;
        w.mode        = mode;
        w.opcode      = opc;
        w.funct3      = f3;
        w.funct7      = f7;
        w.shift_field = sh;
        w.src1_value  = a;
        w.src2_value  = b;
        w.immediate   = imm;
        w.pc_value    = pc;
        return w;
    endfunction

    // operand mix weighted toward sign and wrap corners
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            1:       v = $urandom_range(0, 64);
            2:       v = 32'hFFFF_FFFF - $urandom_range(0, 64);
            3:       v = 32'h8000_0000 + $urandom_range(0, 64) - 32;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_branch_f3();
        logic [2:0] f3;
        case ($urandom_range(0, 5))
            0:       f3 = F3_BEQ;
            1:       f3 = F3_BNE;
            2:       f3 = F3_BLT;
            3:       f3 = F3_BGE;
            4:       f3 = F3_BLTU;
            default: f3 = F3_BGEU;
        endcase
        return f3;
    endfunction

    // mostly well-formed instructions with random operands, the rest raw noise
    function automatic t_in_word gen_insn();
        t_in_word     w;
        logic [191:0] raw;
        int           kind;
        raw  = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        w    = raw[$bits(t_in_word)-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            w.mode   = MODE_R;
            w.opcode = ($urandom_range(0, 9) != 0) ? OPC_REG : w.opcode;
            w.funct7 = ((w.funct3 == F3_ADD || w.funct3 == F3_SR) && $urandom_range(0, 1))
                       ? F7_ALT : F7_BASE;
        end else if (kind < 25) begin
            w.mode   = MODE_R;
            w.opcode = OPC_IMM;
            w.funct3 = $urandom_range(0, 1) ? F3_SLL : F3_SR;
            w.funct7 = (w.funct3 == F3_SR && $urandom_range(0, 1)) ? F7_ALT : F7_BASE;
        end else if (kind < 40) begin
            w.mode   = MODE_I;
            w.opcode = OPC_IMM;
        end else if (kind < 60) begin
            w.mode   = MODE_SB;
            if ($urandom_range(0, 9) != 0)
                w.funct3 = pick_branch_f3();
        end else if (kind < 67) begin
            w.mode = MODE_UJ;
        end else if (kind < 74) begin
            w.mode   = MODE_I;
            w.opcode = OPC_JALR;
        end else if (kind < 82) begin
            w.mode   = ($urandom_range(0, 3) == 0)
                       ? MODE_I : 3'(MODE_OTHER + $urandom_range(0, 3));
            w.opcode = $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC;
        end
        if (kind < 82) begin
            w.src1_value = pick_operand();
            case ($urandom_range(0, 9))
                0, 1:    w.src2_value = w.src1_value;
                2:       w.src2_value = w.src1_value + 1;
                default: w.src2_value = pick_operand();
            endcase
            w.immediate = pick_operand();
            w.pc_value  = pick_operand();
        end
        return w;
    endfunction

    function automatic int pick_idle_pct();
        int pct;
        case ($urandom_range(0, 2))
            0:       pct = 0;
            1:       pct = 10;
            default: pct = 35;
        endcase
        return pct;
    endfunction

    // driver: one word per free slot, random idle bursts except near the end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                result_due.push_back(predict_exec(in_word));
                words_in <= words_in + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (insn_pending.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (insn_pending.size() > TAIL_WORDS
                             && $urandom_range(0, 99) < tx_idle_pct) begin
                    in_valid <= 1'b0;
                    tx_gap   <= $urandom_range(1, 5) - 1;
                end else begin
                    in_valid <= 1'b1;
                    in_word  <= insn_pending.pop_front();
                    if ($urandom_range(0, 127) == 0)
                        tx_idle_pct <= pick_idle_pct();
                end
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off to back the pipe up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_out >= HOLD_AT_WORD) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (rx_gap > 0) begin
            out_ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end else if (insn_pending.size() > TAIL_WORDS && $urandom_range(0, 99) < rx_idle_pct) begin
            out_ready <= 1'b0;
            rx_gap    <= $urandom_range(1, 5) - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 127) == 0)
                rx_idle_pct <= pick_idle_pct();
        end
    end

    // monitor: every output word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word due;
        if (i_rst_n && o_out_valid && out_ready) begin
            words_out <= words_out + 1;
            if (result_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: wv=%b wval=%h jt=%b tgt=%h",
                             o_out_word.write_valid, o_out_word.write_value,
                             o_out_word.jump_taken, o_out_word.jump_target);
            end else begin
                due = result_due.pop_front();
                n_writes    += due.write_valid;
                n_redirects += due.jump_taken;
                if (o_out_word.write_valid !== due.write_valid
                    || o_out_word.write_value !== due.write_value
                    || o_out_word.jump_taken !== due.jump_taken
                    || o_out_word.jump_target !== due.jump_target) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("word %0d mismatch: exp wv=%b wval=%h jt=%b tgt=%h",
                                 words_out, due.write_valid, due.write_value,
                                 due.jump_taken, due.jump_target);
                        $display("    got wv=%b wval=%h jt=%b tgt=%h",
                                 o_out_word.write_valid, o_out_word.write_value,
                                 o_out_word.jump_taken, o_out_word.jump_target);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        bit timed_out;
        timed_out = 1'b0;

        // R-type ALU, corners of sign and wrap
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_ADD, F7_BASE, 5'd0,
                               32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_ADD, F7_ALT, 5'd0,
                               32'h0, 32'h1, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_SLL, F7_BASE, 5'd0,
                               32'h1, 32'h3F, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_SLT, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_SLTU, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_XOR, F7_BASE, 5'd0,
                               32'hFFFF_FFFF, 32'h5555_5555, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_SR, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h1F, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_SR, F7_ALT, 5'd0,
                               32'h8000_0000, 32'h21, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_OR, F7_BASE, 5'd0,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_REG, F3_AND, F7_BASE, 5'd0,
                               32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h0));
        // immediate shifts ride in the R class with the OP-IMM opcode
        insn_pending.push_back(make_insn(MODE_R, OPC_IMM, F3_SLL, F7_BASE, 5'd31,
                               32'h1, 32'h0, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_IMM, F3_SR, F7_BASE, 5'd31,
                               32'h8000_0000, 32'h0, 32'h0, 32'h0));
        insn_pending.push_back(make_insn(MODE_R, OPC_IMM, F3_SR, F7_ALT, 5'd31,
                               32'h8000_0000, 32'h0, 32'h0, 32'h0));
        // I-type ALU
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_ADD, F7_BASE, 5'd0,
                               32'h0, 32'h0, 32'hFFFF_F800, 32'h0));
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_SLT, F7_BASE, 5'd0,
                               32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_SLTU, F7_BASE, 5'd0,
                               32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_XOR, F7_BASE, 5'd0,
                               32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0));
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_OR, F7_BASE, 5'd0,
                               32'h0, 32'h0, 32'h8000_0000, 32'h0));
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_AND, F7_BASE, 5'd0,
                               32'hFFFF_FFFF, 32'h0, 32'h0000_07FF, 32'h0));
        // branches, taken and not, target wrapping past zero
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BEQ, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h8000_0000, 32'h8, 32'hFFFF_FFFC));
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BNE, F7_BASE, 5'd0,
                               32'h5, 32'h5, 32'h8, 32'h100));
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BLT, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h0, 32'hFFFF_FFF0, 32'h100));
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BGE, F7_BASE, 5'd0,
                               32'h8000_0000, 32'h0, 32'h10, 32'h100));
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BLTU, F7_BASE, 5'd0,
                               32'h0, 32'hFFFF_FFFF, 32'h20, 32'h100));
        insn_pending.push_back(make_insn(MODE_SB, OPC_REG, F3_BGEU, F7_BASE, 5'd0,
                               32'h0, 32'hFFFF_FFFF, 32'h20, 32'h100));
        // jumps, link wrap and JALR low bit
        insn_pending.push_back(make_insn(MODE_UJ, 7'h00, F3_ADD, F7_BASE, 5'd0,
                               32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFC));
        insn_pending.push_back(make_insn(MODE_I, OPC_JALR, F3_SLT, F7_BASE, 5'd0,
                               32'hFFFF_FFFF, 32'h0, 32'h0, 32'h40));
        // upper-immediate forms from the other class and an aliased mode
        insn_pending.push_back(make_insn(MODE_ALIAS, OPC_LUI, F3_ADD, F7_BASE, 5'd0,
                               32'h0, 32'h0, 32'hFFFF_F000, 32'h0));
        insn_pending.push_back(make_insn(MODE_OTHER, OPC_AUIPC, F3_ADD, F7_BASE, 5'd0,
                               32'h0, 32'h0, 32'h8000_0000, 32'h8000_0004));
        // no match: nothing written, nothing taken
        insn_pending.push_back(make_insn(MODE_I, OPC_IMM, F3_SLL, F7_BASE, 5'd3,
                               32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0));
        n_directed = insn_pending.size();

        repeat (NUM_RANDOM) insn_pending.push_back(gen_insn());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (insn_pending.size() != 0 || in_valid || result_due.size() != 0) begin
            @(negedge i_clk);
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, result_due.size());
            $display("Test completed with failures");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("%0d words sent, %0d checked (%0d directed, rest random), %0d mismatches",
                     words_in, words_out, n_directed, mismatches);
            $display("%0d register writes, %0d redirects, one %0d-cycle output hold-off",
                     n_writes, n_redirects, HOLD_CYCLES);
            if (mismatches == 0 && result_due.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
